// ----- design/bhb_pkg.sv -----
// Shared types and helpers for the binary heap builder.
// No dependencies; imported by the interfaces and all modules.
package bhb_pkg;

	localparam int VALUE_W = 32;

	typedef logic signed [VALUE_W-1:0] bhb_value_t;

	// True if a should sit above b in the heap (strict order).
	function automatic logic bhb_beats(input bhb_value_t a, input bhb_value_t b,
			input logic min_mode);
		bhb_beats = min_mode ? (a < b) : (a > b);
	endfunction

endpackage

// ----- design/bhb_if.sv -----
// Valid/ready channel interfaces for element input and heap output.
// Depends on bhb_pkg for the value type.
interface bhb_in_if import bhb_pkg::*; ();
	logic       valid;
	logic       ready;
	bhb_value_t value;
	logic       last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface bhb_out_if import bhb_pkg::*; ();
	logic       valid;
	logic       ready;
	bhb_value_t heap_value;
	logic       end_of_heap;
	logic       dropped;

	modport source (output valid, output heap_value, output end_of_heap, output dropped,
		input ready);
	modport sink   (input valid, input heap_value, input end_of_heap, input dropped,
		output ready);
endinterface

// ----- design/bhb_store.sv -----
// Element store: one write port, one read port with registered read data.
// Depends on bhb_pkg for the value type.
module bhb_store import bhb_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  bhb_value_t    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output bhb_value_t    rdata
);

	bhb_value_t mem [DEPTH];
	bhb_value_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/binary_heap_builder_unit.sv -----
// Channel  | Dir | Payload                             | Transfer
// elem     | in  | value, last                         | valid && ready
// heap     | out | heap_value, end_of_heap, dropped    | valid && ready
// cfg      | in  | cfg_wdata (min_heap)                | cfg_we
//
// Loading accepts one element per cycle. The build runs bottom-up over internal
// nodes: each node is read, then each level moved reads the left child and, if
// present, the right child, bounded by the single read port of the store.
// Emission reads each result and then registers it, waiting while the output is
// stalled. Reset clears control state only; the store holds no reset value. A
// stalled output holds the current result while the next set may already load.
// Depends on bhb_pkg, bhb_if and bhb_store.
module binary_heap_builder_unit import bhb_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	bhb_in_if.sink    elem,
	bhb_out_if.source heap
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = AW + 2;

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_NODE  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_GETL  = 3'd3;
	localparam logic [2:0] S_GETR  = 3'd4;
	localparam logic [2:0] S_ERD   = 3'd5;
	localparam logic [2:0] S_EOUT  = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          dropped_q;
	logic          min_heap_q;
	logic          mode_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] node_q;
	logic          first_q;
	bhb_value_t    v_q;
	bhb_value_t    best_val_q;
	logic [AW-1:0] best_idx_q;
	logic          best_child_q;
	logic [CW-1:0] e_q;
	logic          ov_q;
	bhb_value_t    oval_q;
	logic          oend_q;
	logic          odrop_q;

	// store ports
	logic          we;
	logic [AW-1:0] waddr;
	bhb_value_t    wdata;
	logic          re;
	logic [AW-1:0] raddr;
	bhb_value_t    rdata;

	bhb_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// child positions and set size
	logic [LW-1:0] left_w, right_w, n_w;
	assign left_w  = {1'b0, node_q, 1'b1};
	assign right_w = {1'b0, node_q, 1'b0} + LW'(2);
	assign n_w     = {{(LW-CW){1'b0}}, count_q};

	logic has_left, has_right;
	assign has_left  = left_w < n_w;
	assign has_right = right_w < n_w;

	// load side
	logic          in_xfer, room;
	logic [CW-1:0] count_next;
	logic [CW-1:0] k_start;
	logic [CW-1:0] k_start_m1;
	assign elem.ready = (state_q == S_LOAD);
	assign in_xfer    = elem.valid && elem.ready;
	assign room       = count_q < CW'(CAPACITY);
	assign count_next = room ? count_q + 1'b1 : count_q;
	assign k_start    = count_next >> 1;
	assign k_start_m1 = k_start - 1'b1;

	// sift decision on the last child read
	logic          lbeats, rbeats;
	logic          fin_child;
	bhb_value_t    fin_val;
	logic [AW-1:0] fin_idx;
	logic          deciding;
	assign lbeats = bhb_beats(rdata, v_q, mode_q);
	assign rbeats = bhb_beats(rdata, best_val_q, mode_q);
	assign deciding = (state_q == S_GETR) || (state_q == S_GETL && !has_right);

	always_comb begin
		if (state_q == S_GETR) begin
			fin_child = rbeats || best_child_q;
			fin_val   = rbeats ? rdata : best_val_q;
			fin_idx   = rbeats ? right_w[AW-1:0] : best_idx_q;
		end else begin
			fin_child = lbeats;
			fin_val   = rdata;
			fin_idx   = left_w[AW-1:0];
		end
	end

	// next node bookkeeping
	logic [CW-1:0] k_m2;
	logic          last_node;
	assign k_m2      = k_q - CW'(2);
	assign last_node = (k_q == CW'(1));

	logic out_free, e_last;
	assign out_free = !ov_q || heap.ready;
	assign e_last   = (e_q + 1'b1) == count_q;

	// store access
	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = v_q;
		re    = 1'b0;
		raddr = node_q;
		case (state_q)
			S_LOAD: begin
				we    = in_xfer && room;
				waddr = count_q[AW-1:0];
				wdata = elem.value;
			end
			S_NODE: begin
				re = 1'b1;
			end
			S_FETCH: begin
				if (has_left) begin
					re    = 1'b1;
					raddr = left_w[AW-1:0];
				end else begin
					we = !first_q;
				end
			end
			S_GETL, S_GETR: begin
				if (deciding) begin
					we    = 1'b1;
					wdata = fin_child ? fin_val : v_q;
				end else begin
					re    = 1'b1;
					raddr = right_w[AW-1:0];
				end
			end
			S_ERD: begin
				re    = 1'b1;
				raddr = e_q[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_heap_q <= 1'b1;
		end else if (cfg_we) begin
			min_heap_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			dropped_q <= 1'b0;
			mode_q    <= 1'b1;
			k_q       <= '0;
			node_q    <= '0;
			first_q   <= 1'b0;
			e_q       <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						count_q <= count_next;
						ovf_q   <= ovf_q || !room;
						if (elem.last) begin
							dropped_q <= ovf_q || !room;
							mode_q    <= min_heap_q;
							e_q       <= '0;
							k_q       <= k_start;
							node_q    <= k_start_m1[AW-1:0];
							first_q   <= 1'b1;
							state_q   <= (k_start == '0) ? S_ERD : S_NODE;
						end
					end
				end
				S_NODE: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (has_left) begin
						first_q <= 1'b0;
						state_q <= S_GETL;
					end else if (last_node) begin
						first_q <= 1'b0;
						state_q <= S_ERD;
					end else begin
						k_q     <= k_q - 1'b1;
						node_q  <= k_m2[AW-1:0];
						first_q <= 1'b1;
						state_q <= S_NODE;
					end
				end
				S_GETL, S_GETR: begin
					if (!deciding) begin
						state_q <= S_GETR;
					end else if (fin_child) begin
						node_q  <= fin_idx;
						state_q <= S_FETCH;
					end else if (last_node) begin
						state_q <= S_ERD;
					end else begin
						k_q     <= k_q - 1'b1;
						node_q  <= k_m2[AW-1:0];
						first_q <= 1'b1;
						state_q <= S_NODE;
					end
				end
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (out_free) begin
						if (e_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// sifted value and running best child
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH && first_q) begin
			v_q <= rdata;
		end
		if (state_q == S_GETL && has_right) begin
			best_val_q   <= lbeats ? rdata : v_q;
			best_idx_q   <= left_w[AW-1:0];
			best_child_q <= lbeats;
		end
	end

	// output register
	logic out_load;
	assign out_load = (state_q == S_EOUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (heap.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			oval_q  <= rdata;
			oend_q  <= e_last;
			odrop_q <= dropped_q;
		end
	end

	assign heap.valid       = ov_q;
	assign heap.heap_value  = oval_q;
	assign heap.end_of_heap = oend_q;
	assign heap.dropped     = odrop_q;

endmodule
